### rtl/bba_pkg.sv
// bba_pkg: shared types and constants of the block bitmap allocator
// used by bba_front, bba_back and block_bitmap_allocator; no dependencies
package bba_pkg;

  localparam int MAP_BYTES = 64;
  localparam int BLOCKS    = MAP_BYTES * 8;
  localparam int BYTE_AW   = $clog2(MAP_BYTES);
  localparam int QDEPTH    = 2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef enum logic [1:0] {
    OP_FREE = 2'd0,
    OP_USED = 2'd1,
    OP_FIND = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  // classified command kinds
  typedef enum logic [2:0] {
    K_NONE,
    K_ACK,
    K_FREE,
    K_USED,
    K_FIND
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_FIND
  } st_e;

  typedef struct packed {
    kind_e       kind;
    logic [8:0]  rs;
    logic [9:0]  re;
    logic [9:0]  want;
  } cmd_t;

endpackage

### rtl/bba_ram.sv
// bba_ram: generic ram, one write port, two registered read ports
// no dependencies
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/bba_front.sv
// bba_front: accepts beats, classifies them and queues commands
// depends on bba_pkg
module bba_front import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [8:0] range_start_i,
  input  logic [9:0] range_end_i,
  input  logic [9:0] want_count_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  cmd_t       q_q [QDEPTH];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       push;
  cmd_t       cmd_new;
  logic [9:0] re_clip;
  op_e        op;

  assign busy        = (cnt_q == 2'(QDEPTH));
  assign push        = start && !busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];
  assign op          = op_e'(op_i);

  always_comb begin
    re_clip = (range_end_i > 10'(BLOCKS)) ? 10'(BLOCKS) : range_end_i;
    cmd_new.rs   = range_start_i;
    cmd_new.re   = re_clip;
    cmd_new.want = want_count_i;
    unique case (op)
      OP_FREE: cmd_new.kind = ({1'b0, range_start_i} >= re_clip) ? K_ACK : K_FREE;
      OP_USED: cmd_new.kind = ({1'b0, range_start_i} >= re_clip) ? K_ACK : K_USED;
      OP_FIND: cmd_new.kind = (want_count_i == 10'd0) ? K_NONE : K_FIND;
      default: cmd_new.kind = K_NONE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cmd_new;
    end
  end

endmodule

### rtl/bba_back.sv
// bba_back: executes mark and find commands on the bitmap ram and answers the other kinds without a map access
// depends on bba_pkg and bba_ram
module bba_back import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       result_valid_o,
  output logic       found_o,
  output logic [8:0] span_start_o,
  output logic [9:0] span_end_o,
  output logic [9:0] span_length_o
);

  st_e               st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  logic [BYTE_AW-1:0] b_q, b_d;
  logic [9:0]        h_q, h_d, t_q, t_d, cnt_q, cnt_d, he_q, he_d;
  logic [9:0]        bs_q, bs_d, be_q, be_d, bl_q, bl_d;
  logic              got_q, got_d;
  logic              rv_q, rv_d, fd_q, fd_d;
  logic [8:0]        rs_q, rs_d;
  logic [9:0]        re_q, re_d, rl_q, rl_d;
  logic [MAP_BYTES-1:0] vld_q;
  logic              vld_a_q, vld_b_q;
  logic              we;
  logic [BYTE_AW-1:0] addr_a, addr_b;
  logic [7:0]        rd_a, rd_b, old_byte, mask, new_byte;
  logic              hfree, tfree;
  logic [9:0]        hi_blk, span_len;
  logic [8:0]        blk;

  bba_ram #(.WIDTH(8), .DEPTH(MAP_BYTES)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (b_q),
    .wdata_i   (new_byte),
    .raddr_a_i (addr_a),
    .rdata_a_o (rd_a),
    .raddr_b_i (addr_b),
    .rdata_b_o (rd_b)
  );

  assign addr_a   = (st_d == ST_MARK) ? b_d : h_d[BYTE_AW+2:3];
  assign addr_b   = t_d[BYTE_AW+2:3];
  assign hfree    = vld_a_q && rd_a[3'd7 - h_q[2:0]];
  assign tfree    = vld_b_q && rd_b[3'd7 - t_q[2:0]];
  assign old_byte = vld_a_q ? rd_a : BYTE_ZERO;
  assign hi_blk   = cmd_q.re - 10'd1;
  assign span_len = he_q - t_q;

  always_comb begin
    mask = BYTE_ZERO;
    for (int j = 0; j < 8; j++) begin
      blk = {b_q, 3'(j)};
      mask[7-j] = (blk >= cmd_q.rs) && ({1'b0, blk} < cmd_q.re);
    end
    new_byte = (cmd_q.kind == K_FREE) ? (old_byte | mask) : (old_byte & ~mask);
  end

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; b_d = b_q;
    h_d = h_q; t_d = t_q; cnt_d = cnt_q; he_d = he_q;
    bs_d = bs_q; be_d = be_q; bl_d = bl_q; got_d = got_q;
    rv_d = 1'b0; fd_d = fd_q; rs_d = rs_q; re_d = re_q; rl_d = rl_q;
    we = 1'b0; cmd_pop_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            K_NONE, K_ACK: begin
              rv_d = 1'b1; fd_d = (cmd_i.kind == K_ACK);
              rs_d = '0; re_d = '0; rl_d = '0;
            end
            K_FREE, K_USED: begin
              b_d  = cmd_i.rs[BYTE_AW+2:3];
              st_d = ST_MARK;
            end
            default: begin
              h_d = '0; t_d = '0; cnt_d = '0; he_d = '0; got_d = 1'b0;
              st_d = ST_FIND;
            end
          endcase
        end
      end
      ST_MARK: begin
        we = 1'b1;
        if (b_q == hi_blk[BYTE_AW+2:3]) begin
          rv_d = 1'b1; fd_d = 1'b1; rs_d = '0; re_d = '0; rl_d = '0;
          st_d = ST_IDLE;
        end else begin
          b_d = b_q + BYTE_AW'(1);
        end
      end
      default: begin
        if (cnt_q == cmd_q.want) begin
          if (tfree) begin
            if (!got_q || span_len < bl_q) begin
              bs_d = t_q; be_d = he_q; bl_d = span_len; got_d = 1'b1;
            end
            cnt_d = cnt_q - 10'd1;
          end
          t_d = t_q + 10'd1;
        end else if (h_q == 10'(BLOCKS)) begin
          rv_d = 1'b1; fd_d = got_q;
          rs_d = got_q ? bs_q[8:0] : '0;
          re_d = got_q ? be_q : '0;
          rl_d = got_q ? bl_q : '0;
          st_d = ST_IDLE;
        end else begin
          h_d = h_q + 10'd1;
          if (hfree) begin
            cnt_d = cnt_q + 10'd1;
            he_d  = h_q + 10'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      rv_q  <= 1'b0;
      vld_q <= '0;
      got_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      rv_q  <= rv_d;
      got_q <= got_d;
      if (we) begin
        vld_q[b_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; b_q <= b_d;
    h_q <= h_d; t_q <= t_d; cnt_q <= cnt_d; he_q <= he_d;
    bs_q <= bs_d; be_q <= be_d; bl_q <= bl_d;
    fd_q <= fd_d; rs_q <= rs_d; re_q <= re_d; rl_q <= rl_d;
    vld_a_q <= vld_q[addr_a];
    vld_b_q <= vld_q[addr_b];
  end

  assign result_valid_o = rv_q;
  assign found_o        = fd_q;
  assign span_start_o   = rs_q;
  assign span_end_o     = re_q;
  assign span_length_o  = rl_q;

endmodule

### rtl/block_bitmap_allocator.sv
// block_bitmap_allocator: an empty mark, op 3 or a zero count is answered without a map access;
// a mark does a read-modify-write of each touched byte in turn; find steps the head over all 512
// blocks and steps the window tail on while the window holds the wanted count, bit-serial scan.
// a two-beat command queue lets a new beat in while the back end works; a queued beat waits.
// reset (async, low) clears control and the per-byte valid bits: every block used.
// results show for one cycle on result_valid_o; the receiver cannot stall.
module block_bitmap_allocator import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [8:0] range_start_i,
  input  logic [9:0] range_end_i,
  input  logic [9:0] want_count_i,
  output logic       result_valid_o,
  output logic       found_o,
  output logic [8:0] span_start_o,
  output logic [9:0] span_end_o,
  output logic [9:0] span_length_o
);

  // command handoff from front end to back end
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // front: accept and classify (clip range, flag empty ranges, zero counts and bad codes)
  bba_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .want_count_i  (want_count_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // back: byte read-modify-write for marks, sliding window scan for find
  bba_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .span_start_o   (span_start_o),
    .span_end_o     (span_end_o),
    .span_length_o  (span_length_o)
  );

`ifndef NO_ASSERTIONS
  // a miss carries all-zero span fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !found_o |-> span_start_o == 9'd0 && span_end_o == 10'd0
      && span_length_o == 10'd0)
    else $error("miss with nonzero span");

  // length is consistent with start and end
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> span_length_o == span_end_o - {1'b0, span_start_o})
    else $error("span length mismatch");

  // span never runs past the map
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> span_end_o <= 10'(BLOCKS))
    else $error("span end beyond map");
`endif

endmodule
